### sv/spq_pkg.sv
`default_nettype none

package spq_pkg;

    localparam int DEPTH = 16;
    localparam int VAL_W = 32;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int OCC_W = 5;

    typedef logic signed [VAL_W-1:0] t_value;
    typedef logic [CNT_W-1:0] t_count;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_POP_EMPTY  = 2'd1,
        ST_PUSH_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd   cmd;
        t_value in_value;
    } t_in_item;

    typedef struct packed {
        t_value           out_value;
        logic             out_valid;
        t_status          status;
        logic [OCC_W-1:0] occupancy;
    } t_out_item;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctl;

endpackage

`default_nettype wire

### sv/spq_cell.sv
`default_nettype none

module spq_cell
    import spq_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_cell_ctl i_ctl,
    input  wire t_value    i_in_value,
    input  wire logic      i_used,
    input  wire t_value    i_left_value,
    input  wire logic      i_left_le,
    input  wire t_value    i_right_value,
    output t_value         o_value,
    output logic           o_le
);

    t_value r_value;
    t_value n_value;

    // new value belongs here or earlier
    assign o_le    = !i_used || (r_value <= i_in_value);
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        if (i_ctl.pop) begin
            n_value = i_right_value;
        end else if (i_ctl.push && o_le) begin
            n_value = i_left_le ? i_left_value : i_in_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

`default_nettype wire

### sv/sorted_priority_queue_unit.sv
`default_nettype none

// sorted priority queue built as a row of DEPTH value cells
// - input channel: i_valid / o_stall carrying i_item (cmd, in_value)
// - output channel: o_valid / i_stall carrying o_item
//   (out_value, out_valid, status, occupancy)
// - a transaction is taken when valid is high and stall is low
// - every input transaction yields exactly one output transaction
// - the result is registered and shows on o_item in the cycle after acceptance
// - throughput: one transaction per cycle unless the receiver stalls; a push
//   compares against every cell in parallel and shifts the lower part of the
//   row by one cell, a pop shifts the whole row toward the head, both at once
// - cell 0 holds the largest value; equal values put the newest first
// - pop on empty and push on full leave the row untouched and flag status
// - reset clears the entry count and the output valid flag; cell contents
//   are not reset, cells past the count are treated as unused
// - when the receiver stalls, the pending result holds and o_stall is
//   raised, so no new transaction enters until the result is taken
module sorted_priority_queue_unit
    import spq_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_stall,
    input  wire t_in_item  i_item,
    output logic           o_valid,
    input  wire logic      i_stall,
    output t_out_item      o_item
);

    t_count    r_count;
    t_count    n_count;
    logic      r_o_valid;
    t_out_item r_o_item;
    t_out_item n_o_item;

    t_cell_ctl w_ctl;
    t_value    w_value [DEPTH];
    logic      w_le    [DEPTH];
    logic      w_used  [DEPTH];

    logic w_accept;
    logic w_is_pop;
    logic w_empty;
    logic w_full;

    // output register parts the channels; stall only while a result waits
    assign o_stall  = r_o_valid && i_stall;
    assign w_accept = i_valid && !o_stall;
    assign w_is_pop = (i_item.cmd == CMD_POP);
    assign w_empty  = (r_count == '0);
    assign w_full   = (r_count == CNT_W'(DEPTH));

    assign w_ctl.push = w_accept && !w_is_pop && !w_full;
    assign w_ctl.pop  = w_accept && w_is_pop && !w_empty;

    // row of cells, each talking only to its neighbors
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_value w_left_value;
        logic   w_left_le;
        t_value w_right_value;

        assign w_used[g] = (r_count > CNT_W'(g));

        if (g == 0) begin : g_head
            assign w_left_value = '0;
            assign w_left_le    = 1'b0;
        end else begin : g_mid
            assign w_left_value = w_value[g-1];
            assign w_left_le    = w_le[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right_value = '0;
        end else begin : g_body
            assign w_right_value = w_value[g+1];
        end

        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_in_value    (i_item.in_value),
            .i_used        (w_used[g]),
            .i_left_value  (w_left_value),
            .i_left_le     (w_left_le),
            .i_right_value (w_right_value),
            .o_value       (w_value[g]),
            .o_le          (w_le[g])
        );
    end

    // count and result of the transaction being accepted
    always_comb begin
        n_count   = r_count;
        n_o_item  = '0;
        if (w_ctl.push) begin
            n_count = r_count + 1'b1;
        end else if (w_ctl.pop) begin
            n_count = r_count - 1'b1;
        end

        if (w_is_pop) begin
            if (w_empty) begin
                n_o_item.status = ST_POP_EMPTY;
            end else begin
                n_o_item.out_value = w_value[0];
                n_o_item.out_valid = 1'b1;
                n_o_item.status    = ST_OK;
            end
        end else begin
            n_o_item.status = w_full ? ST_PUSH_FULL : ST_OK;
        end
        n_o_item.occupancy = OCC_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count   <= n_count;
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_o_item <= n_o_item;
        end
    end

    assign o_valid = r_o_valid;
    assign o_item  = r_o_item;

    // count never passes the row length
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    // head is never below its neighbor
    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) |-> (w_value[0] >= w_value[1]))
        else $error("row lost descending order");

    // a successful pop lowers the count by one
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.pop |=> (r_count == $past(r_count) - 1'b1))
        else $error("pop did not decrement count");

    // reported occupancy matches the count right after a transaction
    a_occ_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (o_item.occupancy == OCC_W'(r_count)))
        else $error("occupancy disagrees with count");

endmodule

`default_nettype wire

### dv/sorted_priority_queue_unit_test.sv
`timescale 1ns / 100ps

// self-checking bench for the sorted priority queue
module sorted_priority_queue_unit_test;
    import spq_pkg::*;

    localparam t_value VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam t_value VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam int STALL_LIMIT = 400;   // cycles with no transaction before giving up
    localparam int TAIL_CYCLES = 8;     // extra cycles after the last result
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 53;

    // one row of stimulus: the transaction plus how to drive and check it
    typedef struct packed {
        t_in_item  item;
        logic      typed;   // expected result given by hand
        t_out_item want;
        logic      hold;    // wait for every outstanding result first
        logic      quiet;   // no idling on either side
    } t_stim;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_item  i_item;
    logic      o_valid;
    logic      i_stall;
    t_out_item o_item;

    sorted_priority_queue_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    // shadow copy of the sorted row
    t_value    shadow_slots [DEPTH];
    int        shadow_fill;

    t_stim     stim_q [$];
    t_out_item pending_results [$];

    int        error_count;
    int        tx_idx;
    int        tx_gap;
    int        rx_wait;
    int        idle_cycles;
    logic      quiet_now;

    // clock, 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // apply one transaction to the shadow row and return the result it gives
    function automatic t_out_item predict_queue_op(t_in_item it);
        t_out_item r;
        int        pos;
        r = '0;
        r.status = ST_OK;
        if (it.cmd == CMD_POP) begin
            if (shadow_fill == 0) begin
                r.status = ST_POP_EMPTY;
            end else begin
                r.out_value = shadow_slots[0];
                r.out_valid = 1'b1;
                for (int i = 1; i < shadow_fill; i++)
                    shadow_slots[i-1] = shadow_slots[i];
                shadow_fill--;
            end
        end else if (shadow_fill >= DEPTH) begin
            r.status = ST_PUSH_FULL;
        end else begin
            // new value goes ahead of the first value not above it,
            // so equal values keep the newest first; otherwise after the tail
            pos = shadow_fill;
            for (int i = 0; i < shadow_fill; i++) begin
                if (shadow_slots[i] <= it.in_value) begin
                    pos = i;
                    break;
                end
            end
            for (int i = shadow_fill; i > pos; i--)
                shadow_slots[i] = shadow_slots[i-1];
            shadow_slots[pos] = it.in_value;
            shadow_fill++;
        end
        r.occupancy = shadow_fill[OCC_W-1:0];
        return r;
    endfunction

    task automatic add_row(input t_cmd c, input t_value v, input logic typed,
                           input t_value ov, input logic ovd, input t_status st,
                           input int occ);
        t_stim s;
        s = '0;
        s.item.cmd       = c;
        s.item.in_value  = v;
        s.typed          = typed;
        s.want.out_value = ov;
        s.want.out_valid = ovd;
        s.want.status    = st;
        s.want.occupancy = occ[OCC_W-1:0];
        stim_q.push_back(s);
    endtask

    // directed table followed by random phases
    task automatic build_stimulus();
        t_stim s;
        int    push_pct;
        int    val_mode;
        // pop straight after reset hits the empty case
        add_row(CMD_POP,  32'sd0,         1, 32'sd0, 0, ST_POP_EMPTY, 0);
        // fill the row, extremes first, then equal values and bit patterns
        add_row(CMD_PUSH, VAL_MAX,        1, 32'sd0, 0, ST_OK, 1);
        add_row(CMD_PUSH, VAL_MIN,        1, 32'sd0, 0, ST_OK, 2);
        add_row(CMD_PUSH, 32'sd0,         1, 32'sd0, 0, ST_OK, 3);
        add_row(CMD_PUSH, 32'sd0,         1, 32'sd0, 0, ST_OK, 4);
        add_row(CMD_PUSH, -32'sd1,        1, 32'sd0, 0, ST_OK, 5);
        add_row(CMD_PUSH, VAL_MIN,        1, 32'sd0, 0, ST_OK, 6);
        add_row(CMD_PUSH, 32'sh55555555,  1, 32'sd0, 0, ST_OK, 7);
        add_row(CMD_PUSH, 32'shaaaaaaaa,  1, 32'sd0, 0, ST_OK, 8);
        add_row(CMD_PUSH, 32'sd1,         1, 32'sd0, 0, ST_OK, 9);
        add_row(CMD_PUSH, VAL_MAX,        1, 32'sd0, 0, ST_OK, 10);
        add_row(CMD_PUSH, 32'sd7,         1, 32'sd0, 0, ST_OK, 11);
        add_row(CMD_PUSH, -32'sd7,        1, 32'sd0, 0, ST_OK, 12);
        add_row(CMD_PUSH, 32'sh0000ffff,  1, 32'sd0, 0, ST_OK, 13);
        add_row(CMD_PUSH, 32'shffff0000,  1, 32'sd0, 0, ST_OK, 14);
        add_row(CMD_PUSH, 32'sd1,         1, 32'sd0, 0, ST_OK, 15);
        add_row(CMD_PUSH, 32'sd2,         1, 32'sd0, 0, ST_OK, 16);
        // row is full: value is dropped
        add_row(CMD_PUSH, VAL_MAX,        1, 32'sd0, 0, ST_PUSH_FULL, 16);
        // head is the largest; payload on a pop is ignored
        add_row(CMD_POP,  32'sh12345678,  1, VAL_MAX, 1, ST_OK, 15);
        add_row(CMD_POP,  VAL_MIN,        0, 32'sd0, 0, ST_OK, 0);
        add_row(CMD_PUSH, 32'sd3,         0, 32'sd0, 0, ST_OK, 0);
        add_row(CMD_POP,  -32'sd1,        0, 32'sd0, 0, ST_OK, 0);
        add_row(CMD_POP,  32'sd0,         0, 32'sd0, 0, ST_OK, 0);

        // random phases: push-heavy, pop-heavy and balanced traffic
        for (int p = 0; p < PHASES; p++) begin
            case (p % 4)
                0:       push_pct = 75;
                1:       push_pct = 25;
                2:       push_pct = 50;
                default: push_pct = 58;
            endcase
            val_mode = p % 3;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                s = '0;
                s.item.cmd = ($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP;
                case (($urandom_range(3) == 0) ? 0 : val_mode)
                    0: s.item.in_value = $urandom;
                    // narrow range gives many equal values
                    1: s.item.in_value = $signed($urandom_range(6)) - 32'sd3;
                    default: begin
                        case ($urandom_range(4))
                            0:       s.item.in_value = VAL_MAX;
                            1:       s.item.in_value = VAL_MIN;
                            2:       s.item.in_value = 32'sd0;
                            3:       s.item.in_value = -32'sd1;
                            default: s.item.in_value = 32'sd1;
                        endcase
                    end
                endcase
                s.hold  = (k == 0);
                s.quiet = (p % 5 == 2);
                stim_q.push_back(s);
            end
        end
    endtask

    // single process for both channels: results are checked before the
    // input side pushes its prediction, so the queue order is fixed
    always @(posedge i_clk) begin
        logic      tx_accept;
        logic      rx_accept;
        t_out_item want;
        t_out_item pred;
        if (i_rst_n) begin
            tx_accept = i_valid && !o_stall;
            rx_accept = o_valid && !i_stall;

            // output side: compare against the oldest expected result
            if (rx_accept) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result transaction: %p", o_item);
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_item.out_value !== want.out_value) begin
                        $error("out_value: expected %0d, got %0d",
                               want.out_value, o_item.out_value);
                        error_count++;
                    end
                    if (o_item.out_valid !== want.out_valid) begin
                        $error("out_valid: expected %0b, got %0b",
                               want.out_valid, o_item.out_valid);
                        error_count++;
                    end
                    if (o_item.status !== want.status) begin
                        $error("status: expected %0d, got %0d",
                               want.status, o_item.status);
                        error_count++;
                    end
                    if (o_item.occupancy !== want.occupancy) begin
                        $error("occupancy: expected %0d, got %0d",
                               want.occupancy, o_item.occupancy);
                        error_count++;
                    end
                end
                rx_wait = quiet_now ? 0 : $urandom_range(9);
            end
            if (rx_wait > 0) begin
                i_stall <= 1'b1;
                rx_wait--;
            end else begin
                i_stall <= 1'b0;
            end

            // input side: predict on every accepted transaction
            if (tx_accept) begin
                pred = predict_queue_op(stim_q[tx_idx].item);
                pending_results.push_back(stim_q[tx_idx].typed ?
                                          stim_q[tx_idx].want : pred);
                quiet_now = stim_q[tx_idx].quiet;
                tx_idx++;
                tx_gap = (tx_idx < stim_q.size() && stim_q[tx_idx].quiet) ?
                         0 : $urandom_range(9);
            end
            if (i_valid && !tx_accept) begin
                // stalled payload stays put
            end else if (tx_idx < stim_q.size() && tx_gap == 0 &&
                         !(stim_q[tx_idx].hold && pending_results.size() != 0)) begin
                i_valid <= 1'b1;
                i_item  <= stim_q[tx_idx].item;
            end else begin
                i_valid <= 1'b0;
                if (tx_gap > 0)
                    tx_gap--;
            end

            // watchdog on cycles with no transaction on either side
            if (tx_accept || rx_accept)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("sorted_priority_queue_unit_test: done, errors");
                $finish;
            end
        end
    end

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_stall     = 1'b0;
        i_item      = '0;
        error_count = 0;
        tx_idx      = 0;
        tx_gap      = 0;
        rx_wait     = 0;
        idle_cycles = 0;
        quiet_now   = 1'b0;
        shadow_fill = 0;
        foreach (shadow_slots[i])
            shadow_slots[i] = '0;
        build_stimulus();

        // reset held low from the start, once
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // run until every transaction is sent and every result is back
        do
            @(posedge i_clk);
        while (!(tx_idx == stim_q.size() && pending_results.size() == 0));
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("sorted_priority_queue_unit_test: done, clean");
        else
            $display("sorted_priority_queue_unit_test: done, errors");
        $finish;
    end

endmodule

### sorted_priority_queue_unit.f
sv/spq_pkg.sv
sv/spq_cell.sv
sv/sorted_priority_queue_unit.sv
dv/sorted_priority_queue_unit_test.sv
